/* design/sfe_pkg.sv */
// Shared types, line codes and the CRC-16/Modbus byte update for the framer.
// Used by every module of the stuffed frame encoder; has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfe_pkg;

  localparam logic [7:0]  SYNC_BYTE   = 8'hAE;
  localparam logic [7:0]  QUOTE_BYTE  = 8'hAC;
  localparam logic [7:0]  ESC_SYNC    = 8'hCE;
  localparam logic [7:0]  ESC_QUOTE   = 8'hCC;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam int          QUEUE_DEPTH = 4;

  // One accepted body word, classified by the front end.
  typedef struct packed {
    logic [7:0]  data;
    logic        open;   // frame opens with this word
    logic        last;   // frame closes after this word
    logic [15:0] crc;    // running CRC including this word
  } desc_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic  valid;
    desc_t desc;
  } qhead_t;

  typedef enum logic [5:0] {
    PH_START  = 6'b000001,
    PH_OPEN   = 6'b000010,
    PH_DATA   = 6'b000100,
    PH_CRC_LO = 6'b001000,
    PH_CRC_HI = 6'b010000,
    PH_CLOSE  = 6'b100000
  } phase_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* design/stuffed_frame_encoder_crc16.sv */
// Top level of the byte-stuffing frame encoder with CRC-16/Modbus trailer.
// Depends on sfe_pkg, sfe_front, sfe_queue and sfe_back.
`timescale 1ns / 1ps
`default_nettype none

// Body words enter on the body channel and line words leave on the line
// channel, both with valid/ready handshakes. The first body word of a frame is
// preceded by the sync byte 0xAE; each body byte goes out escaped (0xAE as
// 0xAC 0xCE, 0xAC as 0xAC 0xCC). After the word flagged last_byte, the
// CRC-16/Modbus of the unescaped body goes out low byte first, escaped the
// same way, followed by a closing 0xAE with frame_end set. run_last marks the
// final line word caused by each body word. The front end takes one body word
// per cycle while the descriptor queue (QDepth entries) has room, updating
// the CRC in the same cycle. The back end emits one line word per cycle into
// a registered output while a descriptor is queued and the output register is
// empty or taken by line_ready, so a body word causes 1 to 8 line words (one
// for a plain mid-frame byte, two for an escaped byte, plus one for an
// opening sync and up to five for the escaped CRC and closing sync).
// Sustained throughput is therefore set by the back end's line-word count. The
// first line word of a word accepted into an empty encoder passes through the
// queue entry and the registered output before it appears on the line outputs.
module stuffed_frame_encoder_crc16 import sfe_pkg::*; #(
  parameter int QDepth = QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       body_valid,
  output logic            body_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output logic            line_valid,
  input  wire logic       line_ready,
  output logic [7:0]      out_byte,
  output logic            frame_end,
  output logic            run_last
);

  logic   q_full;
  logic   push;
  desc_t  push_desc;
  logic   pop;
  qhead_t head;

  // Front end: frame open/close tracking and CRC update per body word.
  sfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .body_valid (body_valid),
    .body_ready (body_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .push       (push),
    .push_desc  (push_desc)
  );

  // Descriptor queue decoupling acceptance from line output.
  sfe_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .full      (q_full),
    .head      (head)
  );

  // Back end: sequences sync, escaped data, CRC trailer and closing sync.
  sfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .out_byte   (out_byte),
    .frame_end  (frame_end),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

/* design/sfe_front.sv */
// Front end: accepts body words, tracks frame state and the running CRC.
// Depends on sfe_pkg; feeds classified descriptors into sfe_queue.
`timescale 1ns / 1ps
`default_nettype none

module sfe_front import sfe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       body_valid,
  output logic            body_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  input  wire logic       q_full,
  output logic            push,
  output desc_t           push_desc
);

  logic        inside_frame;
  logic [15:0] crc;
  logic [15:0] crc_next;

  assign body_ready = !q_full;
  assign push       = body_valid && body_ready;
  assign crc_next   = crc_add(crc, data_byte);

  always_comb begin
    push_desc.data = data_byte;
    push_desc.open = !inside_frame;
    push_desc.last = last_byte;
    push_desc.crc  = crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame <= 1'b0;
      crc          <= CRC_INIT;
    end else if (push) begin
      inside_frame <= !last_byte;
      crc          <= last_byte ? CRC_INIT : crc_next;
    end
  end

`ifndef SYNTHESIS
  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    push && last_byte |=> !inside_frame && crc == CRC_INIT)
    else $error("frame state not cleared after closing word");
  a_open_holds: assert property (@(posedge clk) disable iff (rst)
    push && !last_byte |=> inside_frame && crc == $past(crc_next))
    else $error("frame state not carried after body word");
`endif

endmodule

`default_nettype wire

/* design/sfe_queue.sv */
// Short descriptor queue between the front and back ends.
// Depends on sfe_pkg; depth comes from the top-level parameter.
`timescale 1ns / 1ps
`default_nettype none

module sfe_queue import sfe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire desc_t push_desc,
  input  wire logic  pop,
  output logic       full,
  output qhead_t     head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntFull);
  assign head.valid = (count != '0);
  assign head.desc  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= CntFull)
    else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

/* design/sfe_back.sv */
// Back end: sends each descriptor's escaped data, with sync, CRC and close as flagged.
// Depends on sfe_pkg; pops sfe_queue and drives the registered line output.
`timescale 1ns / 1ps
`default_nettype none

module sfe_back import sfe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire qhead_t head,
  output logic        pop,
  output logic        line_valid,
  input  wire logic   line_ready,
  output logic [7:0]  out_byte,
  output logic        frame_end,
  output logic        run_last
);

  phase_t     phase;
  phase_t     phase_next;
  phase_t     eff;
  logic       esc_half;
  logic       esc_half_next;
  logic [7:0] src;
  logic [7:0] byte_val;
  logic       byte_done;
  logic       item_done;
  logic       emit;

  always_comb begin
    eff = phase;
    if (phase == PH_START) begin
      eff = head.desc.open ? PH_OPEN : PH_DATA;
    end
    unique case (eff)
      PH_CRC_LO: src = head.desc.crc[7:0];
      PH_CRC_HI: src = head.desc.crc[15:8];
      default:   src = head.desc.data;
    endcase

    if (eff == PH_OPEN || eff == PH_CLOSE) begin
      byte_val  = SYNC_BYTE;
      byte_done = 1'b1;
    end else if (esc_half) begin
      byte_val  = (src == SYNC_BYTE) ? ESC_SYNC : ESC_QUOTE;
      byte_done = 1'b1;
    end else if (src == SYNC_BYTE || src == QUOTE_BYTE) begin
      byte_val  = QUOTE_BYTE;
      byte_done = 1'b0;
    end else begin
      byte_val  = src;
      byte_done = 1'b1;
    end

    item_done = byte_done && (eff == PH_CLOSE || (eff == PH_DATA && !head.desc.last));
    emit      = head.valid && (!line_valid || line_ready);
    pop       = emit && item_done;

    phase_next    = phase;
    esc_half_next = esc_half;
    if (emit) begin
      esc_half_next = !byte_done;
      if (byte_done) begin
        unique case (eff)
          PH_OPEN:   phase_next = PH_DATA;
          PH_DATA:   phase_next = head.desc.last ? PH_CRC_LO : PH_START;
          PH_CRC_LO: phase_next = PH_CRC_HI;
          PH_CRC_HI: phase_next = PH_CLOSE;
          default:   phase_next = PH_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      esc_half   <= 1'b0;
      line_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      esc_half <= esc_half_next;
      if (emit) begin
        line_valid <= 1'b1;
      end else if (line_ready) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= byte_val;
      frame_end <= (eff == PH_CLOSE);
      run_last  <= item_done;
    end
  end

`ifndef SYNTHESIS
  a_close_is_sync: assert property (@(posedge clk) disable iff (rst)
    line_valid && frame_end |-> out_byte == SYNC_BYTE && run_last)
    else $error("closing word is not a final sync byte");
  a_escape_in_payload: assert property (@(posedge clk) disable iff (rst)
    esc_half |-> head.valid && (phase == PH_DATA || phase == PH_CRC_LO ||
                                phase == PH_CRC_HI || phase == PH_START))
    else $error("escape pending outside a payload byte");
  a_pop_on_final: assert property (@(posedge clk) disable iff (rst)
    pop |=> line_valid && run_last)
    else $error("descriptor retired without a final line word");
`endif

endmodule

`default_nettype wire
